/* rtl/core/canap_pkg.sv */
// ============================================================================
// CAN ASCII frame parser package
// Shared types, phase codes, flag masks and character constants for the
// text CAN frame parser, plus the hex digit decoder.
// ============================================================================
package canap_pkg;

    // Widths of the result fields
    localparam int unsigned LEN_W   = 7;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned ID_W    = 32;

    // Parse phases
    localparam logic [2:0] PH_ID       = 3'd0;
    localparam logic [2:0] PH_AFTER_ID = 3'd1;
    localparam logic [2:0] PH_RTR_LEN  = 3'd2;
    localparam logic [2:0] PH_FD_FLAGS = 3'd3;
    localparam logic [2:0] PH_DATA_HI  = 3'd4;
    localparam logic [2:0] PH_DATA_LO  = 3'd5;
    localparam logic [2:0] PH_DONE     = 3'd6;

    // Result kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Frame status codes
    localparam logic [1:0] STATUS_REJECTED = 2'd0;
    localparam logic [1:0] STATUS_CLASSIC  = 2'd1;
    localparam logic [1:0] STATUS_FD       = 2'd2;

    // Identifier flag bits
    localparam logic [ID_W-1:0] FLAG_EFF = 32'h8000_0000;
    localparam logic [ID_W-1:0] FLAG_RTR = 32'h4000_0000;
    localparam logic [ID_W-1:0] FLAG_ERR = 32'h2000_0000;

    // Characters of the frame syntax
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_R_UPPER = 8'h52;
    localparam logic [7:0] CHAR_R_LOWER = 8'h72;

    // Identifier positions at which the delimiter may stand, and the saturated position
    localparam logic [3:0] STD_ID_DIGITS = 4'd3;
    localparam logic [3:0] EXT_ID_DIGITS = 4'd8;
    localparam logic [3:0] POS_SATURATED = 4'd15;

    // Largest remote length that is taken
    localparam logic [3:0] REMOTE_MAX_LEN = 4'd8;

    // One result transaction
    typedef struct packed {
        logic               result_kind;
        logic [7:0]         data_byte;
        logic [INDEX_W-1:0] byte_index;
        logic [ID_W-1:0]    frame_id;
        logic [LEN_W-1:0]   frame_len;
        logic [3:0]         fd_flags;
        logic [1:0]         status;
    } result_t;

    // Decoded hex digit: valid flag and nibble value
    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_digit_t;

    // Decode one ASCII hex digit of either case.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok  = 1'b1;
        d.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.nib = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.nib = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.nib = 4'(c - 8'h57);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

/* rtl/core/can_ascii_frame_parser.sv */
// ============================================================================
// CAN ASCII frame parser
// Decodes a text CAN frame, one character per transaction, into payload
// bytes and a closing frame summary.
// ============================================================================
// Usage:
//   The input channel (in_valid, in_stall, char_code, is_end) carries one
//   character per transaction; a transaction with is_end high closes the
//   frame text. The output channel (out_valid, out_stall and the result
//   fields) carries a payload byte as soon as its second hex digit arrives,
//   and a frame summary for every end transaction.
//   A result is registered in the result register when that is free or
//   being taken, else in the skid register. Throughput is one character
//   per cycle while in_stall is low; the parse state is updated by a single
//   pass of logic between the input handshake and the result register.
//   A two-entry output stage (result register plus skid register) lets the
//   block take a character while a result still waits. in_stall rises only
//   once both entries hold results; it falls again after the receiver
//   takes one.
//   Reset clears the parse state to the identifier phase and empties both
//   output entries. After every end transaction the parse state returns to
//   that same reset value.
// ============================================================================
module can_ascii_frame_parser #(
    parameter int unsigned CLASSIC_MAX_BYTES = 8,
    parameter int unsigned FD_MAX_BYTES      = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Character channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 char_code,
    input  logic                       is_end,
    // Result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       result_kind,
    output logic [7:0]                 data_byte,
    output logic [canap_pkg::INDEX_W-1:0] byte_index,
    output logic [canap_pkg::ID_W-1:0] frame_id,
    output logic [canap_pkg::LEN_W-1:0] frame_len,
    output logic [3:0]                 fd_flags,
    output logic [1:0]                 status
);
    import canap_pkg::*;

    localparam logic [LEN_W-1:0] CLASSIC_LIMIT = LEN_W'(CLASSIC_MAX_BYTES);
    localparam logic [LEN_W-1:0] FD_LIMIT      = LEN_W'(FD_MAX_BYTES);

    // Parse state
    logic [2:0]       phase_reg,       phase_next;
    logic [3:0]       char_pos_reg,    char_pos_next;
    logic [ID_W-1:0]  id_value_reg,    id_value_next;
    logic [LEN_W-1:0] byte_pos_reg,    byte_pos_next;
    logic [3:0]       high_nib_reg,    high_nib_next;
    logic             sep_taken_reg,   sep_taken_next;
    logic             fd_mode_reg,     fd_mode_next;
    logic [3:0]       fd_flags_reg,    fd_flags_next;
    logic [3:0]       remote_len_reg,  remote_len_next;
    logic             error_seen_reg,  error_seen_next;
    logic             is_remote_reg,   is_remote_next;

    // Output stage
    logic             out_valid_reg;
    result_t          out_data_reg;
    logic             skid_valid_reg;
    result_t          skid_data_reg;

    // Per-character results
    logic             in_accept;
    logic             out_take;
    logic             res_valid;
    result_t          res;
    hex_digit_t       hex;
    logic             text_ok;
    logic             do_hi;
    logic             do_lo;
    logic [LEN_W-1:0] byte_pos_inc;
    logic [LEN_W-1:0] limit;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;

    assign hex          = hex_decode(char_code);
    assign byte_pos_inc = byte_pos_reg + LEN_W'(1);
    assign limit        = fd_mode_reg ? FD_LIMIT : CLASSIC_LIMIT;

    // The text so far forms an acceptable frame if it ended here.
    always_comb
    begin
        unique case (phase_reg)
            PH_AFTER_ID, PH_RTR_LEN, PH_DATA_HI: text_ok = 1'b1;
            PH_DONE:                             text_ok = !error_seen_reg;
            default:                             text_ok = 1'b0;
        endcase
    end

    // Next parse state and result for the character on the input.
    always_comb
    begin
        phase_next      = phase_reg;
        char_pos_next   = char_pos_reg;
        id_value_next   = id_value_reg;
        byte_pos_next   = byte_pos_reg;
        high_nib_next   = high_nib_reg;
        sep_taken_next  = sep_taken_reg;
        fd_mode_next    = fd_mode_reg;
        fd_flags_next   = fd_flags_reg;
        remote_len_next = remote_len_reg;
        error_seen_next = error_seen_reg;
        is_remote_next  = is_remote_reg;
        res_valid       = 1'b0;
        res             = '0;
        do_hi           = 1'b0;
        do_lo           = 1'b0;

        if (is_end) begin
            // Frame summary, then back to the reset state
            res_valid       = 1'b1;
            res.result_kind = KIND_SUMMARY;
            if (text_ok) begin
                res.frame_id  = is_remote_reg ? (id_value_reg | FLAG_RTR) : id_value_reg;
                res.frame_len = is_remote_reg ? LEN_W'(remote_len_reg) : byte_pos_reg;
                res.fd_flags  = fd_mode_reg ? fd_flags_reg : 4'd0;
                res.status    = fd_mode_reg ? STATUS_FD : STATUS_CLASSIC;
            end else begin
                res.status    = STATUS_REJECTED;
            end
            phase_next      = PH_ID;
            char_pos_next   = '0;
            id_value_next   = '0;
            byte_pos_next   = '0;
            high_nib_next   = '0;
            sep_taken_next  = 1'b0;
            fd_mode_next    = 1'b0;
            fd_flags_next   = '0;
            remote_len_next = '0;
            error_seen_next = 1'b0;
            is_remote_next  = 1'b0;
        end else if (char_code == CHAR_NUL) begin
            // A NUL closes the text early without a result
            if (phase_reg != PH_DONE) begin
                phase_next      = PH_DONE;
                error_seen_next = !text_ok;
            end
        end else begin
            unique case (phase_reg)
                PH_ID:
                begin
                    if (char_pos_reg == STD_ID_DIGITS && char_code == CHAR_HASH) begin
                        phase_next = PH_AFTER_ID;
                    end else if (char_pos_reg == EXT_ID_DIGITS) begin
                        if (char_code == CHAR_HASH) begin
                            if ((id_value_reg & FLAG_ERR) == '0) begin
                                id_value_next = id_value_reg | FLAG_EFF;
                            end
                            phase_next = PH_AFTER_ID;
                        end else begin
                            phase_next      = PH_DONE;
                            error_seen_next = 1'b1;
                        end
                    end else if (!hex.ok) begin
                        phase_next      = PH_DONE;
                        error_seen_next = 1'b1;
                    end else begin
                        id_value_next = {id_value_reg[ID_W-5:0], hex.nib};
                    end
                    if (char_pos_reg != POS_SATURATED) begin
                        char_pos_next = char_pos_reg + 4'd1;
                    end
                end
                PH_AFTER_ID:
                begin
                    if (char_code == CHAR_R_UPPER || char_code == CHAR_R_LOWER) begin
                        is_remote_next = 1'b1;
                        phase_next     = PH_RTR_LEN;
                    end else if (char_code == CHAR_HASH) begin
                        fd_mode_next = 1'b1;
                        phase_next   = PH_FD_FLAGS;
                    end else begin
                        do_hi = 1'b1;
                    end
                end
                PH_RTR_LEN:
                begin
                    if (hex.ok && hex.nib <= REMOTE_MAX_LEN) begin
                        remote_len_next = hex.nib;
                    end
                    phase_next = PH_DONE;
                end
                PH_FD_FLAGS:
                begin
                    if (!hex.ok) begin
                        phase_next      = PH_DONE;
                        error_seen_next = 1'b1;
                    end else begin
                        fd_flags_next = hex.nib;
                        phase_next    = PH_DATA_HI;
                    end
                end
                PH_DATA_HI: do_hi = 1'b1;
                PH_DATA_LO: do_lo = 1'b1;
                default:    ;
            endcase

            // First digit of a payload byte, or its optional separator
            if (do_hi) begin
                if (char_code == CHAR_DOT && !sep_taken_reg) begin
                    sep_taken_next = 1'b1;
                    phase_next     = PH_DATA_HI;
                end else if (!hex.ok) begin
                    phase_next      = PH_DONE;
                    error_seen_next = 1'b1;
                end else begin
                    high_nib_next = hex.nib;
                    phase_next    = PH_DATA_LO;
                end
            end

            // Second digit completes a payload byte
            if (do_lo) begin
                if (!hex.ok) begin
                    phase_next      = PH_DONE;
                    error_seen_next = 1'b1;
                end else begin
                    res_valid       = 1'b1;
                    res.result_kind = KIND_BYTE;
                    res.data_byte   = {high_nib_reg, hex.nib};
                    res.byte_index  = byte_pos_reg[INDEX_W-1:0];
                    byte_pos_next   = byte_pos_inc;
                    sep_taken_next  = 1'b0;
                    phase_next      = (byte_pos_inc >= limit) ? PH_DONE : PH_DATA_HI;
                end
            end
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_ID;
            char_pos_reg   <= '0;
            id_value_reg   <= '0;
            byte_pos_reg   <= '0;
            high_nib_reg   <= '0;
            sep_taken_reg  <= 1'b0;
            fd_mode_reg    <= 1'b0;
            fd_flags_reg   <= '0;
            remote_len_reg <= '0;
            error_seen_reg <= 1'b0;
            is_remote_reg  <= 1'b0;
        end else if (in_accept) begin
            phase_reg      <= phase_next;
            char_pos_reg   <= char_pos_next;
            id_value_reg   <= id_value_next;
            byte_pos_reg   <= byte_pos_next;
            high_nib_reg   <= high_nib_next;
            sep_taken_reg  <= sep_taken_next;
            fd_mode_reg    <= fd_mode_next;
            fd_flags_reg   <= fd_flags_next;
            remote_len_reg <= remote_len_next;
            error_seen_reg <= error_seen_next;
            is_remote_reg  <= is_remote_next;
        end
    end

    // Output stage control: the skid entry drains first, so order is kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take || !out_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (out_take || !out_valid_reg) begin
            out_valid_reg <= in_accept && res_valid;
        end else if (in_accept && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (out_take || !out_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (out_take || !out_valid_reg) begin
            out_data_reg <= res;
        end else if (in_accept && res_valid) begin
            skid_data_reg <= res;
        end
    end

    // Result ports
    assign out_valid   = out_valid_reg;
    assign result_kind = out_data_reg.result_kind;
    assign data_byte   = out_data_reg.data_byte;
    assign byte_index  = out_data_reg.byte_index;
    assign frame_id    = out_data_reg.frame_id;
    assign frame_len   = out_data_reg.frame_len;
    assign fd_flags    = out_data_reg.fd_flags;
    assign status      = out_data_reg.status;

endmodule

/* verif/can_ascii_frame_checker.sv */
// ============================================================================
// CAN ASCII frame parser checker
// Watches the character and result channels of the parser, keeps its own
// copy of the parse state, predicts every payload byte and frame summary,
// and compares each accepted result with the oldest prediction.
// ============================================================================
module can_ascii_frame_checker #(
    parameter int unsigned CLASSIC_MAX_BYTES = 8,
    parameter int unsigned FD_MAX_BYTES      = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [7:0]                    char_code,
    input  logic                          is_end,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          result_kind,
    input  logic [7:0]                    data_byte,
    input  logic [canap_pkg::INDEX_W-1:0] byte_index,
    input  logic [canap_pkg::ID_W-1:0]    frame_id,
    input  logic [canap_pkg::LEN_W-1:0]   frame_len,
    input  logic [3:0]                    fd_flags,
    input  logic [1:0]                    status,
    output int                            mismatch_count,
    output int                            pending_results,
    output int                            bytes_checked,
    output int                            classic_frames,
    output int                            fd_frames,
    output int                            rejected_frames
);
    import canap_pkg::*;

    localparam logic [4:0] NOT_HEX    = 5'd16;
    localparam int         REPORT_MAX = 10;

    // Predicted parse state
    logic [2:0]      phase;
    logic [3:0]      char_pos;
    logic [ID_W-1:0] id_acc;
    logic [6:0]      payload_pos;
    logic [3:0]      high_nib;
    logic            dot_taken;
    logic            fd_mode;
    logic [3:0]      fd_bits;
    logic [3:0]      remote_len;
    logic            text_bad;
    logic            remote;

    // Results still owed by the block, oldest first
    result_t expected_results[$];

    int errors;
    int byte_total;
    int classic_total;
    int fd_total;
    int rejected_total;

    // Value of one ASCII hex digit, or NOT_HEX for any other character.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return {1'b0, 4'(c - "0")};
        end
        if (c >= "A" && c <= "F")
        begin
            return {1'b0, 4'(c - "A" + 8'd10)};
        end
        if (c >= "a" && c <= "f")
        begin
            return {1'b0, 4'(c - "a" + 8'd10)};
        end
        return NOT_HEX;
    endfunction

    // Whether the text seen so far would close as a valid frame.
    function automatic bit frame_text_ok();
        case (phase)
            PH_AFTER_ID, PH_RTR_LEN, PH_DATA_HI: return 1'b1;
            PH_DONE:                             return !text_bad;
            default:                             return 1'b0;
        endcase
    endfunction

    task automatic clear_parser();
        phase       = PH_ID;
        char_pos    = '0;
        id_acc      = '0;
        payload_pos = '0;
        high_nib    = '0;
        dot_taken   = 1'b0;
        fd_mode     = 1'b0;
        fd_bits     = '0;
        remote_len  = '0;
        text_bad    = 1'b0;
        remote      = 1'b0;
    endtask

    task automatic mark_rejected();
        phase    = PH_DONE;
        text_bad = 1'b1;
    endtask

    // Advance the predicted parse by one character transaction.
    task automatic advance_parser(input logic [7:0] c, input logic e);
        logic [4:0]  nib;
        int unsigned limit;
        result_t     r;
        bit          ok;
        bit          take_data;
        nib       = nibble_of(c);
        limit     = fd_mode ? FD_MAX_BYTES : CLASSIC_MAX_BYTES;
        r         = '0;
        take_data = 1'b0;

        // The end transaction always yields a summary and restarts the parse.
        if (e)
        begin
            ok            = frame_text_ok();
            r.result_kind = KIND_SUMMARY;
            r.status      = STATUS_REJECTED;
            if (ok)
            begin
                r.frame_id  = id_acc | (remote ? FLAG_RTR : '0);
                r.frame_len = remote ? LEN_W'(remote_len) : payload_pos;
                r.fd_flags  = fd_mode ? fd_bits : 4'd0;
                r.status    = fd_mode ? STATUS_FD : STATUS_CLASSIC;
            end
            expected_results.push_back(r);
            clear_parser();
            return;
        end

        // A NUL closes the text early; nothing after it counts.
        if (c == CHAR_NUL)
        begin
            if (phase != PH_DONE)
            begin
                ok       = frame_text_ok();
                phase    = PH_DONE;
                text_bad = !ok;
            end
            return;
        end

        case (phase)
            PH_ID:
            begin
                if (char_pos == STD_ID_DIGITS && c == CHAR_HASH)
                begin
                    phase = PH_AFTER_ID;
                end
                else if (char_pos == EXT_ID_DIGITS)
                begin
                    if (c == CHAR_HASH)
                    begin
                        if ((id_acc & FLAG_ERR) == '0)
                        begin
                            id_acc = id_acc | FLAG_EFF;
                        end
                        phase = PH_AFTER_ID;
                    end
                    else
                    begin
                        mark_rejected();
                    end
                end
                else if (nib == NOT_HEX)
                begin
                    mark_rejected();
                end
                else
                begin
                    id_acc = {id_acc[ID_W-5:0], nib[3:0]};
                end
                if (char_pos < POS_SATURATED)
                begin
                    char_pos = char_pos + 4'd1;
                end
            end
            PH_AFTER_ID:
            begin
                if (c == CHAR_R_UPPER || c == CHAR_R_LOWER)
                begin
                    remote = 1'b1;
                    phase  = PH_RTR_LEN;
                end
                else if (c == CHAR_HASH)
                begin
                    fd_mode = 1'b1;
                    phase   = PH_FD_FLAGS;
                end
                else
                begin
                    phase     = PH_DATA_HI;
                    take_data = 1'b1;
                end
            end
            PH_RTR_LEN:
            begin
                if (nib <= REMOTE_MAX_LEN)
                begin
                    remote_len = nib[3:0];
                end
                phase = PH_DONE;
            end
            PH_FD_FLAGS:
            begin
                if (nib == NOT_HEX)
                begin
                    mark_rejected();
                end
                else
                begin
                    fd_bits = nib[3:0];
                    phase   = PH_DATA_HI;
                end
            end
            PH_DATA_HI, PH_DATA_LO:
            begin
                take_data = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (!take_data)
        begin
            return;
        end

        // First digit of a pair, optionally after a single separator.
        if (phase == PH_DATA_HI)
        begin
            if (c == CHAR_DOT && !dot_taken)
            begin
                dot_taken = 1'b1;
            end
            else if (nib == NOT_HEX)
            begin
                mark_rejected();
            end
            else
            begin
                high_nib = nib[3:0];
                phase    = PH_DATA_LO;
            end
            return;
        end

        // Second digit completes a payload byte.
        if (nib == NOT_HEX)
        begin
            mark_rejected();
            return;
        end
        r.result_kind = KIND_BYTE;
        r.data_byte   = {high_nib, nib[3:0]};
        r.byte_index  = payload_pos[INDEX_W-1:0];
        expected_results.push_back(r);
        payload_pos = payload_pos + 7'd1;
        dot_taken   = 1'b0;
        phase       = (payload_pos >= limit) ? PH_DONE : PH_DATA_HI;
    endtask

    // Compare one accepted result transaction with the oldest prediction.
    task automatic check_result();
        result_t got;
        result_t want;
        got.result_kind = result_kind;
        got.data_byte   = data_byte;
        got.byte_index  = byte_index;
        got.frame_id    = frame_id;
        got.frame_len   = frame_len;
        got.fd_flags    = fd_flags;
        got.status      = status;
        if (expected_results.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_MAX)
            begin
                $display("Unexpected result: kind=%0d byte=%02h idx=%0d id=%08h len=%0d",
                         got.result_kind, got.data_byte, got.byte_index, got.frame_id,
                         got.frame_len);
            end
            return;
        end
        want = expected_results.pop_front();
        if (got.result_kind !== want.result_kind || got.data_byte !== want.data_byte ||
            got.byte_index !== want.byte_index || got.frame_id !== want.frame_id ||
            got.frame_len !== want.frame_len || got.fd_flags !== want.fd_flags ||
            got.status !== want.status)
        begin
            errors++;
            if (errors <= REPORT_MAX)
            begin
                $display("Mismatch: expected kind=%0d byte=%02h idx=%0d id=%08h",
                         want.result_kind, want.data_byte, want.byte_index, want.frame_id);
                $display("                   len=%0d flags=%0h status=%0d",
                         want.frame_len, want.fd_flags, want.status);
                $display("          actual   kind=%0d byte=%02h idx=%0d id=%08h",
                         got.result_kind, got.data_byte, got.byte_index, got.frame_id);
                $display("                   len=%0d flags=%0h status=%0d",
                         got.frame_len, got.fd_flags, got.status);
            end
            return;
        end
        if (want.result_kind == KIND_BYTE)
        begin
            byte_total++;
        end
        else if (want.status == STATUS_CLASSIC)
        begin
            classic_total++;
        end
        else if (want.status == STATUS_FD)
        begin
            fd_total++;
        end
        else
        begin
            rejected_total++;
        end
    endtask

    // Results are checked before the new character is predicted, since a
    // character cannot produce a result in the cycle it is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_parser();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            if (in_valid && !in_stall)
            begin
                advance_parser(char_code, is_end);
            end
        end
        mismatch_count  <= errors;
        pending_results <= expected_results.size();
        bytes_checked   <= byte_total;
        classic_frames  <= classic_total;
        fd_frames       <= fd_total;
        rejected_frames <= rejected_total;
    end

endmodule

/* verif/tb_can_ascii_frame_parser.sv */
// ============================================================================
// CAN ASCII frame parser testbench
// Feeds text CAN frames one character per transaction, directed cases first
// and then random well-formed and damaged frames, under three patterns of
// sender and receiver idling. The checker beside the block predicts and
// compares every result; this module gives the verdict.
// ============================================================================
module tb_can_ascii_frame_parser;
    import canap_pkg::*;

    localparam int unsigned CLASSIC_MAX = 8;
    localparam int unsigned FD_MAX      = 64;
    localparam int          PHASE_ITEMS = 500;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 10;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [7:0]         char_code = 8'd0;
    logic               is_end    = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               result_kind;
    logic [7:0]         data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [ID_W-1:0]    frame_id;
    logic [LEN_W-1:0]   frame_len;
    logic [3:0]         fd_flags;
    logic [1:0]         status;

    int mismatch_count;
    int pending_results;
    int bytes_checked;
    int classic_frames;
    int fd_frames;
    int rejected_frames;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int items_sent  = 0;
    int frames_sent = 0;
    int quiet_cycles = 0;

    logic [7:0] frame_text[$];

    can_ascii_frame_parser #(
        .CLASSIC_MAX_BYTES(CLASSIC_MAX),
        .FD_MAX_BYTES     (FD_MAX)
    ) dut (.*);

    can_ascii_frame_checker #(
        .CLASSIC_MAX_BYTES(CLASSIC_MAX),
        .FD_MAX_BYTES     (FD_MAX)
    ) frame_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver stalls at random according to the current idling pattern.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Count cycles in which neither channel completes a transaction.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
        $display("FAILURE");
        $finish;
    end

    // Hex digit character of either case.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return 8'("0" + nib);
        end
        if ($urandom_range(1) == 0)
        begin
            return 8'("A" + nib - 8'd10);
        end
        return 8'("a" + nib - 8'd10);
    endfunction

    // A character likely to matter to the syntax, or any byte at all.
    function automatic logic [7:0] noise_char();
        case ($urandom_range(5))
            0:       return hex_char(4'($urandom_range(15)));
            1:       return CHAR_HASH;
            2:       return CHAR_DOT;
            3:       return ($urandom_range(1) == 0) ? CHAR_R_UPPER : CHAR_R_LOWER;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            frame_text.push_back(s[i]);
        end
    endtask

    task automatic add_hex_digits(input int n);
        repeat (n)
        begin
            frame_text.push_back(hex_char(4'($urandom_range(15))));
        end
    endtask

    // Payload pairs, each preceded by a separator now and then.
    task automatic add_payload(input int n_bytes, input int dot_pct);
        repeat (n_bytes)
        begin
            if ($urandom_range(99) < dot_pct)
            begin
                frame_text.push_back(CHAR_DOT);
            end
            add_hex_digits(2);
        end
    endtask

    // Drive one character transaction and wait until it is taken.
    task automatic drive_char(input logic [7:0] c, input logic e);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        is_end    <= e;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Send the text built so far, closed by an end transaction.
    task automatic send_frame();
        foreach (frame_text[i])
        begin
            drive_char(frame_text[i], 1'b0);
        end
        drive_char(8'($urandom_range(255)), 1'b1);
        frames_sent++;
        frame_text.delete();
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_frame();
    endtask

    // Sender stops until every predicted result has been taken.
    task automatic hold_off();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results == 0);
        @(posedge clk);
    endtask

    // Damage a frame in one of several ways.
    task automatic corrupt_frame();
        int n;
        n = frame_text.size();
        case ($urandom_range(5))
            0:
            begin
                if (n > 0)
                begin
                    frame_text[$urandom_range(n - 1)] = 8'($urandom_range(255));
                end
            end
            1:
            begin
                repeat ($urandom_range(n))
                begin
                    void'(frame_text.pop_back());
                end
            end
            2: frame_text.insert($urandom_range(n), CHAR_NUL);
            3:
            begin
                frame_text.delete();
                repeat ($urandom_range(12))
                begin
                    frame_text.push_back(noise_char());
                end
            end
            4:
            begin
                if (n > 0)
                begin
                    frame_text.delete($urandom_range(n - 1));
                end
            end
            default: frame_text.insert($urandom_range(n), CHAR_DOT);
        endcase
    endtask

    // Build a random frame: mostly well formed, some damaged.
    task automatic build_random_frame();
        int kind;
        kind = $urandom_range(9);
        if ($urandom_range(1) == 0)
        begin
            add_hex_digits(3);
        end
        else
        begin
            add_hex_digits(8);
        end
        frame_text.push_back(CHAR_HASH);
        if (kind < 2)
        begin
            // Remote frame with an optional length of any kind.
            frame_text.push_back(($urandom_range(1) == 0) ? CHAR_R_UPPER : CHAR_R_LOWER);
            case ($urandom_range(3))
                0: ;
                1: frame_text.push_back(8'("0" + $urandom_range(8)));
                2: frame_text.push_back(hex_char(4'($urandom_range(15))));
                default: frame_text.push_back(noise_char());
            endcase
            repeat ($urandom_range(2))
            begin
                frame_text.push_back(noise_char());
            end
        end
        else if (kind < 4)
        begin
            // FD frame, mostly short, now and then past the FD limit.
            frame_text.push_back(CHAR_HASH);
            add_hex_digits(1);
            if ($urandom_range(9) == 0)
            begin
                add_payload($urandom_range(FD_MAX - 14, FD_MAX + 2), 25);
            end
            else
            begin
                add_payload($urandom_range(12), 25);
            end
        end
        else
        begin
            add_payload($urandom_range(CLASSIC_MAX + 2), 25);
        end
        if ($urandom_range(9) == 0)
        begin
            frame_text.push_back(CHAR_DOT);
        end
        if ($urandom_range(99) < 20)
        begin
            corrupt_frame();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 12;
        rx_idle_pct = 45;

        // Directed frames: syntax variants, limits and each reject path.
        send_text("123#11.22");
        send_text("12345678#R3");
        send_text("123##1AABB");
        send_text("7ff#");
        send_text("3FFFFFFF#00");
        add_text("1fffffff#");
        add_payload(CLASSIC_MAX + 2, 0);
        send_frame();
        add_text("000##F");
        add_payload(FD_MAX + 2, 50);
        send_frame();
        send_text("12");
        send_text("1234");
        send_text("1234567#");
        send_text("12G#00");
        send_text("123-00");
        send_text("123#1G");
        send_text("123#..11");
        send_text("123##");
        send_text("123##G0");
        send_text("123#112");
        send_text("123#R9");
        send_text("123#rX11");
        send_text("123#R");
        send_text("123#11.");
        add_text("123#11");
        frame_text.push_back(CHAR_NUL);
        add_text("22");
        send_frame();
        add_text("12");
        frame_text.push_back(CHAR_NUL);
        send_frame();

        // Random frames under three idling patterns.
        for (int p = 0; p < 3; p++)
        begin
            tx_idle_pct = (p == 0) ? 12 : (p == 1) ? 45 : 0;
            rx_idle_pct = (p == 0) ? 45 : (p == 1) ? 12 : 0;
            hold_off();
            while (items_sent < (p + 1) * PHASE_ITEMS)
            begin
                build_random_frame();
                send_frame();
                if ($urandom_range(39) == 0)
                begin
                    hold_off();
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d character transactions in %0d frames.", items_sent, frames_sent);
        $display("Checked %0d payload bytes and %0d summaries",
                 bytes_checked, classic_frames + fd_frames + rejected_frames);
        $display("(%0d classic, %0d FD, %0d rejected).",
                 classic_frames, fd_frames, rejected_frames);
        if (pending_results != 0)
        begin
            $display("%0d predicted results never arrived", pending_results);
        end
        if (mismatch_count == 0 && pending_results == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
